>>> rtl/core/ccsg_pkg.sv
// Shared types, codes and constants of the coulomb counting fuel gauge.
package ccsg_pkg;

   localparam int CUR_W = 16;
   localparam int DUR_W = 16;
   localparam int PROD_W = CUR_W + DUR_W;
   localparam int SOC_W = 14;
   localparam int STATUS_W = 2;
   localparam int NET_W = 48;
   localparam int TOT_W = 47;
   localparam int CAP_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // capacity * 3600 stays below 2^28, remainder * 10000 below 2^42
   localparam int DENOM_W = 28;
   localparam int NUM_W = 42;
   localparam int QUO_W = 14;
   localparam int QSUM_W = 15;
   localparam int SOCX_W = 17;
   localparam int DIV_CNT_W = 4;

   localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
   localparam logic [QUO_W-1:0] SOC_SCALE = 14'd10000;
   localparam logic [SOC_W-1:0] SOC_MAX = 14'd10000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SOC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_THR = 2'd3;

   // register reset values
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd15000;
   localparam logic [SOC_W-1:0] INIT_SOC_RESET = 14'd8000;
   localparam logic [SOC_W-1:0] LOW_THR_RESET = 14'd2000;
   localparam logic [SOC_W-1:0] MOD_THR_RESET = 14'd5000;

   // status band codes
   localparam logic [STATUS_W-1:0] STATUS_LOW = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MODERATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HEALTHY = 2'd2;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic [SOC_W-1:0] init_soc;
      logic [SOC_W-1:0] low_thr;
      logic [SOC_W-1:0] mod_thr;
   } ccsg_cfg_type;

   typedef struct packed {
      logic             charge;
      logic [CUR_W-1:0] mag;
      logic [DUR_W-1:0] dur;
   } ccsg_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_ACC,
      BK_DIFF,
      BK_WHOLE,
      BK_SCALE,
      BK_DIV,
      BK_FIN
   } ccsg_back_state_type;

endpackage

>>> rtl/core/ccsg_if.sv
// Valid/ready channel interfaces for samples and results.
interface ccsg_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [ccsg_pkg::CUR_W-1:0]        current_centiamps;
   logic        [ccsg_pkg::DUR_W-1:0]        duration_seconds;

   modport source (output valid, output current_centiamps, output duration_seconds,
                   input ready);
   modport sink (input valid, input current_centiamps, input duration_seconds,
                 output ready);
endinterface

interface ccsg_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic        [ccsg_pkg::SOC_W-1:0]        soc_centipercent;
   logic        [ccsg_pkg::STATUS_W-1:0]     soc_status;
   logic signed [ccsg_pkg::NET_W-1:0]        net_charge;
   logic        [ccsg_pkg::TOT_W-1:0]        charged_out;
   logic        [ccsg_pkg::TOT_W-1:0]        discharged_out;

   modport source (output valid, output soc_centipercent, output soc_status,
                   output net_charge, output charged_out, output discharged_out,
                   input ready);
   modport sink (input valid, input soc_centipercent, input soc_status,
                 input net_charge, input charged_out, input discharged_out,
                 output ready);
endinterface

>>> rtl/core/ccsg_front.sv
// Front end: accept samples, drop zero-duration ones, split current into direction and size.
module ccsg_front (
   ccsg_req_if.sink                  req_chan,
   output logic                      push_valid,
   output ccsg_pkg::ccsg_entry_type  push_entry,
   input  logic                      push_ready
);

   logic [ccsg_pkg::CUR_W-1:0] cur_bits;

   assign cur_bits = req_chan.current_centiamps;

   // take every transaction the queue has room for; only nonzero durations go on
   assign req_chan.ready = push_ready;
   assign push_valid = req_chan.valid && (req_chan.duration_seconds != '0);

   always_comb begin
      push_entry.charge = cur_bits[ccsg_pkg::CUR_W-1];
      push_entry.mag = cur_bits[ccsg_pkg::CUR_W-1] ? (~cur_bits + 16'd1) : cur_bits;
      push_entry.dur = req_chan.duration_seconds;
   end

endmodule

>>> rtl/core/ccsg_queue.sv
// Short queue of classified samples between front and back ends.
module ccsg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  ccsg_pkg::ccsg_entry_type  push_entry,
   output logic                      push_ready,
   output logic                      pop_valid,
   output ccsg_pkg::ccsg_entry_type  pop_entry,
   input  logic                      pop_ready
);

   ccsg_pkg::ccsg_entry_type           slot_ff [ccsg_pkg::QUEUE_DEPTH];
   logic [ccsg_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ccsg_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ccsg_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push, do_pop;

   assign push_ready = (count_ff != ccsg_pkg::QCNT_W'(ccsg_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ccsg_pkg::QPTR_W'(ccsg_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ccsg_pkg::QPTR_W'(ccsg_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/ccsg_back.sv
// Back end: accumulate charge, divide for state of charge, hold the result register.
module ccsg_back #(
   parameter int CHARGE_BITS = 47
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ccsg_pkg::ccsg_cfg_type    cfg,
   input  logic                      pop_valid,
   input  ccsg_pkg::ccsg_entry_type  pop_entry,
   output logic                      pop_ready,
   ccsg_rsp_if.source                rsp_chan
);

   localparam int CB = CHARGE_BITS;

   ccsg_pkg::ccsg_back_state_type        state_ff, state_in;
   ccsg_pkg::ccsg_entry_type             entry_ff;
   logic [ccsg_pkg::PROD_W-1:0]          prod_ff;
   logic [CB-1:0]                        charged_ff, charged_in;
   logic [CB-1:0]                        discharged_ff, discharged_in;
   logic [CB:0]                          acc_sum;
   logic [CB-1:0]                        acc_new;
   logic signed [CB:0]                   net_ff;
   logic                                 neg_ff;
   logic [CB-1:0]                        mag_ff;
   logic [ccsg_pkg::DENOM_W-1:0]         denom_ff;
   logic [ccsg_pkg::CAP_W-1:0]           cap_eff;
   logic                                 whole_ff, sat_ff;
   logic [ccsg_pkg::DENOM_W-1:0]         rem_ff;
   logic [ccsg_pkg::NUM_W-1:0]           div_rem_ff, dsh_ff;
   logic [ccsg_pkg::QUO_W-1:0]           quo_ff;
   logic [ccsg_pkg::DIV_CNT_W-1:0]       cnt_ff;
   logic                                 div_take;
   logic [ccsg_pkg::QSUM_W-1:0]          qsum;
   logic signed [ccsg_pkg::SOCX_W-1:0]   soc_raw;
   logic [ccsg_pkg::SOC_W-1:0]           soc_val;
   logic [ccsg_pkg::STATUS_W-1:0]        status_val;
   logic                                 rsp_valid_ff;
   logic                                 out_free, load_out, acc_en;

   logic [ccsg_pkg::SOC_W-1:0]           soc_ff;
   logic [ccsg_pkg::STATUS_W-1:0]        status_ff;
   logic signed [ccsg_pkg::NET_W-1:0]    net_out_ff;
   logic [ccsg_pkg::TOT_W-1:0]           chg_out_ff, dis_out_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign div_take = (div_rem_ff >= dsh_ff);
   assign cap_eff = (cfg.capacity == '0) ? 16'd1 : cfg.capacity;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccsg_pkg::BK_IDLE:  if (pop_valid) state_in = ccsg_pkg::BK_MUL;
         ccsg_pkg::BK_MUL:   state_in = ccsg_pkg::BK_ACC;
         ccsg_pkg::BK_ACC:   state_in = ccsg_pkg::BK_DIFF;
         ccsg_pkg::BK_DIFF:  state_in = ccsg_pkg::BK_WHOLE;
         ccsg_pkg::BK_WHOLE: begin
            // a quotient of two or more whole units clamps anyway
            if ((mag_ff >= CB'({denom_ff, 1'b0}))) state_in = ccsg_pkg::BK_FIN;
            else state_in = ccsg_pkg::BK_SCALE;
         end
         ccsg_pkg::BK_SCALE: state_in = ccsg_pkg::BK_DIV;
         ccsg_pkg::BK_DIV:   if (cnt_ff == '0) state_in = ccsg_pkg::BK_FIN;
         ccsg_pkg::BK_FIN:   if (out_free) state_in = ccsg_pkg::BK_IDLE;
         default:            state_in = ccsg_pkg::BK_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      pop_ready = 1'b0;
      acc_en = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ccsg_pkg::BK_IDLE: pop_ready = 1'b1;
         ccsg_pkg::BK_ACC:  acc_en = 1'b1;
         ccsg_pkg::BK_FIN:  load_out = out_free;
         default: begin
         end
      endcase
   end

   // saturating accumulate into the selected total
   always_comb begin
      acc_sum = {1'b0, (entry_ff.charge ? charged_ff : discharged_ff)} + (CB + 1)'(prod_ff);
      acc_new = acc_sum[CB] ? '1 : acc_sum[CB-1:0];
      charged_in = charged_ff;
      discharged_in = discharged_ff;
      if (entry_ff.charge) begin
         charged_in = acc_new;
      end else begin
         discharged_in = acc_new;
      end
   end

   // final state of charge and band
   always_comb begin
      if (sat_ff) begin
         qsum = '1;
      end else begin
         qsum = (whole_ff ? ccsg_pkg::QSUM_W'(ccsg_pkg::SOC_SCALE) : '0)
                + ccsg_pkg::QSUM_W'(quo_ff);
      end
      if (neg_ff) begin
         soc_raw = $signed(ccsg_pkg::SOCX_W'(cfg.init_soc)) + $signed(ccsg_pkg::SOCX_W'(qsum));
      end else begin
         soc_raw = $signed(ccsg_pkg::SOCX_W'(cfg.init_soc)) - $signed(ccsg_pkg::SOCX_W'(qsum));
      end
      if (soc_raw < 0) begin
         soc_val = '0;
      end else if (soc_raw > $signed(ccsg_pkg::SOCX_W'(ccsg_pkg::SOC_MAX))) begin
         soc_val = ccsg_pkg::SOC_MAX;
      end else begin
         soc_val = soc_raw[ccsg_pkg::SOC_W-1:0];
      end
      if (soc_val <= cfg.low_thr) begin
         status_val = ccsg_pkg::STATUS_LOW;
      end else if (soc_val <= cfg.mod_thr) begin
         status_val = ccsg_pkg::STATUS_MODERATE;
      end else begin
         status_val = ccsg_pkg::STATUS_HEALTHY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccsg_pkg::BK_IDLE;
         charged_ff <= '0;
         discharged_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acc_en) begin
            charged_ff <= charged_in;
            discharged_ff <= discharged_in;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ccsg_pkg::BK_IDLE: begin
            entry_ff <= pop_entry;
         end
         ccsg_pkg::BK_MUL: begin
            prod_ff <= ccsg_pkg::PROD_W'(entry_ff.mag) * ccsg_pkg::PROD_W'(entry_ff.dur);
         end
         ccsg_pkg::BK_DIFF: begin
            net_ff <= $signed({1'b0, discharged_ff}) - $signed({1'b0, charged_ff});
            neg_ff <= (charged_ff > discharged_ff);
            mag_ff <= (charged_ff > discharged_ff) ? (charged_ff - discharged_ff)
                                                  : (discharged_ff - charged_ff);
            denom_ff <= ccsg_pkg::DENOM_W'(cap_eff)
                        * ccsg_pkg::DENOM_W'(ccsg_pkg::SECONDS_PER_HOUR);
         end
         ccsg_pkg::BK_WHOLE: begin
            sat_ff <= (mag_ff >= CB'({denom_ff, 1'b0}));
            whole_ff <= (mag_ff >= CB'(denom_ff));
            rem_ff <= (mag_ff >= CB'(denom_ff))
                      ? ccsg_pkg::DENOM_W'(mag_ff - CB'(denom_ff))
                      : ccsg_pkg::DENOM_W'(mag_ff);
         end
         ccsg_pkg::BK_SCALE: begin
            div_rem_ff <= ccsg_pkg::NUM_W'(rem_ff) * ccsg_pkg::NUM_W'(ccsg_pkg::SOC_SCALE);
            dsh_ff <= ccsg_pkg::NUM_W'(denom_ff) << (ccsg_pkg::QUO_W - 1);
            quo_ff <= '0;
            cnt_ff <= ccsg_pkg::DIV_CNT_W'(ccsg_pkg::QUO_W - 1);
         end
         ccsg_pkg::BK_DIV: begin
            // one quotient bit per cycle, denominator walks down one place
            if (div_take) begin
               div_rem_ff <= div_rem_ff - dsh_ff;
            end
            quo_ff <= {quo_ff[ccsg_pkg::QUO_W-2:0], div_take};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
      if (load_out) begin
         soc_ff <= soc_val;
         status_ff <= status_val;
         net_out_ff <= ccsg_pkg::NET_W'(net_ff);
         chg_out_ff <= ccsg_pkg::TOT_W'(charged_ff);
         dis_out_ff <= ccsg_pkg::TOT_W'(discharged_ff);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.soc_centipercent = soc_ff;
   assign rsp_chan.soc_status = status_ff;
   assign rsp_chan.net_charge = net_out_ff;
   assign rsp_chan.charged_out = chg_out_ff;
   assign rsp_chan.discharged_out = dis_out_ff;

endmodule

>>> rtl/core/coulomb_counting_soc_gauge.sv
// Top level of the coulomb counting state-of-charge gauge.
// Each sample (signed current in 0.01 A, duration in seconds) adds current times
// duration to a saturating charged or discharged total; a sample of zero duration
// is dropped and gives no result. Every other sample yields one result: state of
// charge in 0.01 % (initial value minus net charge scaled by capacity*3600, truncated
// toward zero and clamped to 0..10000), a low/moderate/healthy band, the net charge
// and both totals. In the back end a sample is popped, its current and duration are
// multiplied and the product is accumulated; then the net and denominator, the whole
// part and the scaled remainder are formed, the compare-subtract divider yields the
// fractional quotient, and the result register is loaded. When the net charge reaches
// two capacities the scaling and the divider are skipped. The divider sets the rate; a
// two-entry queue lets the front end keep taking samples while it runs, and the result
// register lets a new sample start while an old result waits.
// Write configuration registers only while no sample is in flight.
module coulomb_counting_soc_gauge #(
   parameter int CHARGE_BITS = 47
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ccsg_req_if.sink                              req_chan,
   ccsg_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [ccsg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ccsg_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   ccsg_pkg::ccsg_cfg_type    cfg_ff;
   logic                      push_valid, push_ready;
   ccsg_pkg::ccsg_entry_type  push_entry;
   logic                      pop_valid, pop_ready;
   ccsg_pkg::ccsg_entry_type  pop_entry;

   // configuration registers; narrow ones keep the low bits of the write data
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity <= ccsg_pkg::CAPACITY_RESET;
         cfg_ff.init_soc <= ccsg_pkg::INIT_SOC_RESET;
         cfg_ff.low_thr <= ccsg_pkg::LOW_THR_RESET;
         cfg_ff.mod_thr <= ccsg_pkg::MOD_THR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ccsg_pkg::CSR_CAPACITY: cfg_ff.capacity <= csr_write_data;
            ccsg_pkg::CSR_INIT_SOC: cfg_ff.init_soc <= csr_write_data[ccsg_pkg::SOC_W-1:0];
            ccsg_pkg::CSR_LOW_THR:  cfg_ff.low_thr <= csr_write_data[ccsg_pkg::SOC_W-1:0];
            ccsg_pkg::CSR_MOD_THR:  cfg_ff.mod_thr <= csr_write_data[ccsg_pkg::SOC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // classify and drop zero-duration samples
   ccsg_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // hold classified samples while the back end works
   ccsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // accumulate, divide and deliver one result per queued sample
   ccsg_back #(
      .CHARGE_BITS (CHARGE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> rtl/core/ccsg_checker.sv
// Port-level checks of the gauge, bound to the top level.
module ccsg_checker #(
   parameter int CHARGE_BITS = 47
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [ccsg_pkg::SOC_W-1:0]            rsp_soc,
   input logic [ccsg_pkg::STATUS_W-1:0]         rsp_status,
   input logic [ccsg_pkg::NET_W-1:0]            rsp_net,
   input logic [ccsg_pkg::TOT_W-1:0]            rsp_charged,
   input logic [ccsg_pkg::TOT_W-1:0]            rsp_discharged
);

   // a waiting transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_soc) && $stable(rsp_net))
      else $error("result changed while stalled");

   a_soc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_soc <= ccsg_pkg::SOC_MAX)
      else $error("state of charge above full scale");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ccsg_pkg::STATUS_LOW
                    || rsp_status == ccsg_pkg::STATUS_MODERATE
                    || rsp_status == ccsg_pkg::STATUS_HEALTHY)
      else $error("undefined status band");

   a_net_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CHARGE_BITS > ccsg_pkg::TOT_W)
                    || rsp_net == (ccsg_pkg::NET_W'(rsp_discharged)
                                   - ccsg_pkg::NET_W'(rsp_charged)))
      else $error("net charge disagrees with totals");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind coulomb_counting_soc_gauge ccsg_checker #(
   .CHARGE_BITS (CHARGE_BITS)
) u_ccsg_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_soc        (rsp_chan.soc_centipercent),
   .rsp_status     (rsp_chan.soc_status),
   .rsp_net        (rsp_chan.net_charge),
   .rsp_charged    (rsp_chan.charged_out),
   .rsp_discharged (rsp_chan.discharged_out)
);
